/* rtl/cdt_pkg.sv */
package cdt_pkg;

    localparam int QUBITS_DEF       = 256;
    localparam int MAX_CONTROLS_DEF = 4;
    localparam int DEPTH_BITS_DEF   = 32;

    localparam int FIELD_CONTROLS = 4;
    localparam int ID_BITS        = 8;
    localparam int CNT_BITS       = 32;
    localparam int KIND_SLOTS     = 20;
    localparam int SLOT_BITS      = 5;

    localparam logic [3:0]           KIND_MEASURE = 4'd9;
    localparam logic [SLOT_BITS-1:0] SLOT_MEASURE = 5'd18;

    typedef struct packed {
        logic [3:0]         gate_kind;
        logic               is_controlled;
        logic [ID_BITS-1:0] target_qubit;
        logic [2:0]         control_count;
        logic [ID_BITS-1:0] control_a;
        logic [ID_BITS-1:0] control_b;
        logic [ID_BITS-1:0] control_c;
        logic [ID_BITS-1:0] control_d;
    } gate_in_t;

    typedef struct packed {
        logic [CNT_BITS-1:0] gate_depth;
        logic [CNT_BITS-1:0] total_depth;
        logic [CNT_BITS-1:0] kind_total;
        logic [CNT_BITS-1:0] op_index;
    } gate_out_t;

    // Clamp a value of up to 64 bits to the 32-bit result range.
    function automatic logic [CNT_BITS-1:0] clamp_out(input logic [63:0] v);
        return (|v[63:CNT_BITS]) ? '1 : v[CNT_BITS-1:0];
    endfunction

    function automatic logic [CNT_BITS-1:0] sat_inc_cnt(input logic [CNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // Measure shares one slot; other kinds split on the controlled flag.
    function automatic logic [SLOT_BITS-1:0] kind_slot(input logic [3:0] kind, input logic ctl);
        return (kind == KIND_MEASURE) ? SLOT_MEASURE : {kind, ctl};
    endfunction

endpackage

/* rtl/circuit_depth_tracker_unit.sv */
// Circuit depth tracker: as-soon-as-possible levelization of gate events.
// Gate channel: gate_valid/gate_stall carry one gate event (kind, controlled
// flag, target qubit, control count and four control qubit indices). A
// transfer happens on a rising edge with gate_valid high and gate_stall low.
// Result channel: result_valid/result_stall carry gate depth, circuit depth,
// kind count and operation index, one result per gate, in order.
// Each participating qubit has a lane holding its own copy of the depth table;
// all lanes read in one cycle, a merge stage takes the max, then the new depth
// is written to every copy once per used lane, one lane address a cycle.
// After the gate transfer the block steps through the merge, depth and write
// states; result_valid rises at the end of the write sequence, once the output
// register is free. The write sequence is serialized by the single write port
// of each table copy. The gate side is stalled while a gate is in work.
// The result sits in an output register: the next gate is taken while it
// waits, and a stalled result holds until transferred. When the result is
// still stalled at the end of a gate, the block holds until it is free.
// Reset clears counters and state, then a clearing pass zeroes the depth table,
// one entry a cycle at addresses 0 to QUBITS-1; gate_stall stays high meanwhile.
module circuit_depth_tracker_unit
    import cdt_pkg::*;
#(
    parameter int QUBITS       = QUBITS_DEF,
    parameter int MAX_CONTROLS = MAX_CONTROLS_DEF,
    parameter int DEPTH_BITS   = DEPTH_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      gate_valid,
    output logic      gate_stall,
    input  gate_in_t  gate,
    output logic      result_valid,
    input  logic      result_stall,
    output gate_out_t result
);

    localparam int CTRL_LANES = (MAX_CONTROLS < FIELD_CONTROLS) ? MAX_CONTROLS : FIELD_CONTROLS;
    localparam int LANES      = 1 + CTRL_LANES;
    localparam int QB         = $clog2(QUBITS);
    localparam int SW         = $clog2(LANES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MERGE,
        S_DEPTH,
        S_WRITE,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [QB-1:0]         clr_reg, clr_next;
    logic [SW-1:0]         step_reg, step_next;
    logic [3:0]            kind_reg;
    logic                  ctl_reg;
    logic [DEPTH_BITS-1:0] depth_reg, depth_next;
    logic [DEPTH_BITS-1:0] cd_reg, cd_next;
    logic [CNT_BITS-1:0]   cnt_reg [KIND_SLOTS];
    logic [CNT_BITS-1:0]   cnt_next [KIND_SLOTS];
    logic [CNT_BITS-1:0]   kt_reg, kt_next;
    logic [CNT_BITS-1:0]   op_reg, op_next;
    logic                  result_valid_reg, result_valid_next;
    gate_out_t             result_reg, result_next;

    logic                  accept;
    logic                  out_free;
    logic                  out_load;
    logic [2:0]            count_clamped;
    logic [ID_BITS-1:0]    ctl_ids [FIELD_CONTROLS];
    logic [DEPTH_BITS-1:0] lane_depth [LANES];
    logic [QB-1:0]         lane_addr [LANES];
    logic                  lane_en [LANES];
    logic [DEPTH_BITS-1:0] top;
    logic                  wr_en;
    logic [QB-1:0]         wr_addr;
    logic [DEPTH_BITS-1:0] wr_data;
    logic [SLOT_BITS-1:0]  slot;
    logic [CNT_BITS-1:0]   slot_inc;

    assign gate_stall = (state_reg != S_IDLE);
    assign accept     = gate_valid && !gate_stall;
    assign out_free   = !result_valid_reg || !result_stall;

    assign count_clamped = (gate.control_count > 3'(CTRL_LANES)) ? 3'(CTRL_LANES)
                                                                 : gate.control_count;
    assign ctl_ids[0] = gate.control_a;
    assign ctl_ids[1] = gate.control_b;
    assign ctl_ids[2] = gate.control_c;
    assign ctl_ids[3] = gate.control_d;

    // Broadcast write: clearing pass, or one lane address per step.
    assign wr_en   = (state_reg == S_CLEAR) || ((state_reg == S_WRITE) && lane_en[step_reg]);
    assign wr_addr = (state_reg == S_CLEAR) ? clr_reg : lane_addr[step_reg];
    assign wr_data = (state_reg == S_CLEAR) ? '0 : depth_reg;

    generate
        for (genvar i = 0; i < LANES; i++)
        begin : g_lane
            logic [ID_BITS-1:0] lane_id;
            logic               lane_used;

            if (i == 0)
            begin : g_target
                assign lane_id   = gate.target_qubit;
                assign lane_used = 1'b1;
            end
            else
            begin : g_control
                assign lane_id   = ctl_ids[i-1];
                assign lane_used = (3'(i) <= count_clamped);
            end

            cdt_lane #(
                .QUBITS     (QUBITS),
                .DEPTH_BITS (DEPTH_BITS)
            ) u_lane (
                .clk     (clk),
                .rst_n   (rst_n),
                .load    (accept),
                .id      (lane_id),
                .used    (lane_used),
                .wr_en   (wr_en),
                .wr_addr (wr_addr),
                .wr_data (wr_data),
                .depth   (lane_depth[i]),
                .addr    (lane_addr[i]),
                .en      (lane_en[i])
            );
        end
    endgenerate

    cdt_merge #(
        .LANES      (LANES),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_merge (
        .clk        (clk),
        .load       (state_reg == S_MERGE),
        .lane_depth (lane_depth),
        .top        (top)
    );

    assign slot     = kind_slot(kind_reg, ctl_reg);
    assign slot_inc = sat_inc_cnt(cnt_reg[slot]);

    always_comb
    begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        step_next         = step_reg;
        depth_next        = depth_reg;
        cd_next           = cd_reg;
        cnt_next          = cnt_reg;
        kt_next           = kt_reg;
        op_next           = op_reg;
        out_load          = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == QB'(QUBITS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                state_next = S_DEPTH;
            end
            S_DEPTH:
            begin
                // Saturate the new depth at the top of its range.
                depth_next = (&top) ? top : top + 1'b1;
                op_next    = sat_inc_cnt(op_reg);
                if (kind_reg <= KIND_MEASURE)
                begin
                    cnt_next[slot] = slot_inc;
                    kt_next        = slot_inc;
                end
                else
                begin
                    kt_next = '0;
                end
                step_next  = '0;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (step_reg == '0 && depth_reg > cd_reg)
                begin
                    cd_next = depth_reg;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == SW'(LANES - 1))
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        result_next.gate_depth  = clamp_out(64'(depth_reg));
        result_next.total_depth = clamp_out(64'(cd_reg));
        result_next.kind_total  = kt_reg;
        result_next.op_index    = op_reg;

        if (out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_stall)
        begin
            result_valid_next = result_valid_reg;
        end
        else
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            step_reg         <= '0;
            cd_reg           <= '0;
            kt_reg           <= '0;
            op_reg           <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            for (int i = 0; i < KIND_SLOTS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            step_reg         <= step_next;
            cd_reg           <= cd_next;
            kt_reg           <= kt_next;
            op_reg           <= op_next;
            result_valid_reg <= result_valid_next;
            cnt_reg          <= cnt_next;
            if (out_load)
            begin
                result_reg <= result_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        depth_reg <= depth_next;
        if (accept)
        begin
            kind_reg <= gate.gate_kind;
            ctl_reg  <= gate.is_controlled;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A result can only appear at the end of a gate's write sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> ($past(state_reg) == S_WRITE || $past(state_reg) == S_DONE))
        else $error("result appeared outside the end of a gate");

    // No result while the depth table is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !result_valid)
        else $error("result valid during clearing pass");

    // Circuit depth never falls.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (cd_reg >= $past(cd_reg)))
        else $error("circuit depth decreased");

    // Every gate lands at depth one or more.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.gate_depth != '0))
        else $error("gate depth of zero");

endmodule

/* rtl/cdt_ram.sv */
module cdt_ram
    import cdt_pkg::*;
#(
    parameter int WIDTH = DEPTH_BITS_DEF,
    parameter int DEPTH = QUBITS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/cdt_lane.sv */
module cdt_lane
    import cdt_pkg::*;
#(
    parameter int QUBITS     = QUBITS_DEF,
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic [ID_BITS-1:0]        id,
    input  logic                      used,
    input  logic                      wr_en,
    input  logic [$clog2(QUBITS)-1:0] wr_addr,
    input  logic [DEPTH_BITS-1:0]     wr_data,
    output logic [DEPTH_BITS-1:0]     depth,
    output logic [$clog2(QUBITS)-1:0] addr,
    output logic                      en
);

    localparam int QB = $clog2(QUBITS);

    logic [QB-1:0]         addr_reg;
    logic                  en_reg;
    logic [QB-1:0]         rd_addr;
    logic [DEPTH_BITS-1:0] rd_data;
    logic                  in_range;

    assign rd_addr  = QB'(id);
    assign in_range = 32'(id) < QUBITS;

    // Private copy of the depth table; every copy sees the same writes.
    cdt_ram #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (QUBITS)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= 1'b0;
        end
        else if (load)
        begin
            en_reg <= used && in_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_reg <= rd_addr;
        end
    end

    // Drop qubits that do not take part from the max.
    assign depth = en_reg ? rd_data : '0;
    assign addr  = addr_reg;
    assign en    = en_reg;

endmodule

/* rtl/cdt_merge.sv */
module cdt_merge
    import cdt_pkg::*;
#(
    parameter int LANES      = 1 + MAX_CONTROLS_DEF,
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  load,
    input  logic [DEPTH_BITS-1:0] lane_depth [LANES],
    output logic [DEPTH_BITS-1:0] top
);

    logic [DEPTH_BITS-1:0] top_reg;
    logic [DEPTH_BITS-1:0] top_next;

    always_comb
    begin
        top_next = lane_depth[0];
        for (int i = 1; i < LANES; i++)
        begin
            if (lane_depth[i] > top_next)
            begin
                top_next = lane_depth[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            top_reg <= top_next;
        end
    end

    assign top = top_reg;

endmodule

/* verif/circuit_depth_tracker_unit_tb.sv */
module circuit_depth_tracker_unit_tb;
    import cdt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] KIND_X             = 4'd0;
    localparam logic [3:0] KIND_Z             = 4'd2;
    localparam logic [3:0] KIND_H             = 4'd3;
    localparam logic [3:0] KIND_T             = 4'd6;
    localparam logic [3:0] KIND_ROT           = 4'd8;
    localparam logic [3:0] KIND_FIRST_UNKNOWN = 4'd10;
    localparam logic [3:0] KIND_LAST          = 4'd15;

    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS = 150;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      gate_valid = 1'b0;
    logic      gate_stall;
    gate_in_t  gate = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    gate_out_t result;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int quiet_cycles = 0;

    // Shadow of the block's state
    logic [DEPTH_BITS_DEF-1:0] qubit_depth [QUBITS_DEF];
    logic [DEPTH_BITS_DEF-1:0] circuit_depth = '0;
    logic [CNT_BITS-1:0]       kind_count [KIND_SLOTS];
    logic [CNT_BITS-1:0]       op_count = '0;

    gate_out_t pending_results [$];

    circuit_depth_tracker_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .gate_valid   (gate_valid),
        .gate_stall   (gate_stall),
        .gate         (gate),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #4 clk = ~clk;

    initial
    begin
        foreach (qubit_depth[i])
            qubit_depth[i] = '0;
        foreach (kind_count[i])
            kind_count[i] = '0;
    end

    function automatic gate_out_t predict_gate(input gate_in_t g);
        logic [ID_BITS-1:0]        ids [FIELD_CONTROLS + 1];
        logic [DEPTH_BITS_DEF-1:0] top;
        logic [DEPTH_BITS_DEF-1:0] depth;
        logic [SLOT_BITS-1:0]      slot;
        int                        n;
        gate_out_t                 r;
        ids[0] = g.target_qubit;
        ids[1] = g.control_a;
        ids[2] = g.control_b;
        ids[3] = g.control_c;
        ids[4] = g.control_d;
        n = int'(g.control_count);
        if (n > MAX_CONTROLS_DEF)
            n = MAX_CONTROLS_DEF;
        if (n > FIELD_CONTROLS)
            n = FIELD_CONTROLS;
        n = n + 1;
        top = '0;
        for (int i = 0; i < n; i++)
            if (int'(ids[i]) < QUBITS_DEF && qubit_depth[ids[i]] > top)
                top = qubit_depth[ids[i]];
        depth = (&top) ? top : top + 1'b1;
        // A repeated qubit just gets the same depth twice
        for (int i = 0; i < n; i++)
            if (int'(ids[i]) < QUBITS_DEF)
                qubit_depth[ids[i]] = depth;
        if (depth > circuit_depth)
            circuit_depth = depth;
        if (!(&op_count))
            op_count = op_count + 1'b1;
        r.gate_depth  = depth;
        r.total_depth = circuit_depth;
        r.op_index    = op_count;
        r.kind_total  = '0;
        if (g.gate_kind <= KIND_MEASURE)
        begin
            if (g.gate_kind == KIND_MEASURE)
                slot = SLOT_MEASURE;
            else
                slot = SLOT_BITS'(2 * int'(g.gate_kind) + int'(g.is_controlled));
            if (!(&kind_count[slot]))
                kind_count[slot] = kind_count[slot] + 1'b1;
            r.kind_total = kind_count[slot];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Predict on gate transfers, check on result transfers, watch for a hang
    always @(posedge clk)
    begin
        gate_out_t want;
        bit        moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (gate_valid && !gate_stall)
            begin
                pending_results.insert(pending_results.size(), predict_gate(gate));
                moved = 1'b1;
            end
            if (result_valid && !result_stall)
            begin
                moved = 1'b1;
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("result op_index %0d with none pending",
                                              result.op_index));
                else
                begin
                    want = pending_results.pop_front();
                    if (result.gate_depth !== want.gate_depth)
                        report_mismatch($sformatf("op %0d gate_depth got %0d want %0d",
                                        want.op_index, result.gate_depth, want.gate_depth));
                    if (result.total_depth !== want.total_depth)
                        report_mismatch($sformatf("op %0d total_depth got %0d want %0d",
                                        want.op_index, result.total_depth, want.total_depth));
                    if (result.kind_total !== want.kind_total)
                        report_mismatch($sformatf("op %0d kind_total got %0d want %0d",
                                        want.op_index, result.kind_total, want.kind_total));
                    if (result.op_index !== want.op_index)
                        report_mismatch($sformatf("op %0d op_index got %0d want %0d",
                                        want.op_index, result.op_index, want.op_index));
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
        result_stall <= ($urandom_range(99) < recv_stall_pct);

    // Hold the payload until the transfer, then maybe drop valid for a while
    task automatic send_gate(input gate_in_t g);
        gate       <= g;
        gate_valid <= 1'b1;
        @(posedge clk);
        while (gate_stall)
            @(posedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            gate_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
    endtask

    function automatic gate_in_t make_gate(input logic [3:0] kind, input logic ctl,
                                           input logic [7:0] tgt, input logic [2:0] cnt,
                                           input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c, input logic [7:0] d);
        gate_in_t g;
        g.gate_kind     = kind;
        g.is_controlled = ctl;
        g.target_qubit  = tgt;
        g.control_count = cnt;
        g.control_a     = a;
        g.control_b     = b;
        g.control_c     = c;
        g.control_d     = d;
        return g;
    endfunction

    // Mostly a small pool of qubits so depth chains build up
    function automatic logic [7:0] pick_qubit(input bit narrow);
        return narrow ? 8'($urandom_range(7)) : 8'($urandom_range(255));
    endfunction

    function automatic gate_in_t random_gate();
        gate_in_t g;
        bit       narrow;
        narrow = ($urandom_range(3) != 0);
        if ($urandom_range(9) == 0)
            g.gate_kind = 4'($urandom_range(KIND_LAST, KIND_FIRST_UNKNOWN));
        else
            g.gate_kind = 4'($urandom_range(KIND_MEASURE));
        g.is_controlled = 1'($urandom_range(1));
        g.target_qubit  = pick_qubit(narrow);
        if ($urandom_range(7) == 0)
            g.control_count = 3'($urandom_range(7, FIELD_CONTROLS + 1));
        else
            g.control_count = 3'($urandom_range(FIELD_CONTROLS));
        g.control_a = pick_qubit(narrow);
        g.control_b = pick_qubit(narrow);
        g.control_c = pick_qubit(narrow);
        g.control_d = pick_qubit(narrow);
        if ($urandom_range(9) == 0)
            g.control_b = g.target_qubit;
        return g;
    endfunction

    task automatic run_random(input int items, input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        repeat (items)
            send_gate(random_gate());
    endtask

    task automatic test_gate_kinds();
        // Every kind, known and unknown, both flag values over the sweep
        for (int k = 0; k <= int'(KIND_LAST); k++)
            send_gate(make_gate(4'(k), 1'(k), 8'(k), 3'(k % 5),
                                8'(k + 16), 8'(k + 17), 8'(k + 18), 8'(k + 19)));
        send_gate(make_gate(KIND_MEASURE, 1'b0, 8'd9, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    endtask

    task automatic test_qubit_extremes();
        send_gate(make_gate(KIND_X, 1'b1, 8'd255, 3'd4, 8'd255, 8'd255, 8'd255, 8'd255));
        send_gate(make_gate(KIND_H, 1'b0, 8'd0, 3'd7, 8'd0, 8'd1, 8'd2, 8'd3));
        send_gate(make_gate(KIND_T, 1'b1, 8'd1, 3'd5, 8'd255, 8'd0, 8'd4, 8'd5));
        send_gate(make_gate(KIND_ROT, 1'b1, 8'd6, 3'd6, 8'd255, 8'd2, 8'd7, 8'd0));
        send_gate(make_gate(KIND_Z, 1'b0, 8'd128, 3'd0, 8'd255, 8'd255, 8'd255, 8'd255));
        send_gate(make_gate(KIND_LAST, 1'b1, 8'd255, 3'd7, 8'd255, 8'd255, 8'd255, 8'd255));
    endtask

    task automatic test_back_to_back();
        run_random(PHASE_ITEMS, 0, 0);
    endtask

    task automatic test_sender_gaps();
        run_random(PHASE_ITEMS, 84, 0);
    endtask

    task automatic test_result_backpressure();
        run_random(PHASE_ITEMS, 0, 84);
    endtask

    task automatic test_mixed_idle();
        run_random(PHASE_ITEMS, 37, 37);
    endtask

    initial
    begin
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        test_gate_kinds();
        test_qubit_extremes();
        test_back_to_back();
        test_sender_gaps();
        test_result_backpressure();
        test_mixed_idle();
        gate_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
rtl/cdt_pkg.sv
rtl/cdt_ram.sv
rtl/cdt_lane.sv
rtl/cdt_merge.sv
rtl/circuit_depth_tracker_unit.sv
verif/circuit_depth_tracker_unit_tb.sv
